>>> rtl/scc_pkg.sv
// Shared constants and types for the strongly connected components block.
// Used by strongly_connected_components, scc_checker and the test; depends on nothing else.
package scc_pkg;

    localparam int MAX_V = 64;
    localparam int VW = $clog2(MAX_V);
    localparam int CW = VW + 1;
    localparam int SW = CW + VW;

    typedef enum logic [1:0]
    {
        OP_ADD = 2'd0,
        OP_CLR = 2'd1,
        OP_RUN = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    localparam logic [0:0] REG_VERTEX_COUNT = 1'd0;

endpackage

>>> rtl/strongly_connected_components.sv
// Top level of the strongly connected components block (Kosaraju search).
// Holds the adjacency matrix and both stacks in synchronous memories.
// Depends on scc_pkg.
//
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tuser: op; tdata: from_vertex, to_vertex
//  m_*      | out       | tdata: vertex, component; tlast: end_of_run;
//           |           | tuser: end_of_component, bad_vertex
//  APB      | config    | vertex_count at byte address 0
//
// An accepted edge reads its matrix row in ST_IDLE and writes it back in ST_ADD_WR; a
// rejected edge waits in ST_BAD for the output register; a clear or ignored code ends in ST_IDLE.
// In a run, the row scan of the first pass tests one matrix bit a cycle, and the column
// walk of the second pass reads a matrix row from the single port for each bit it tests,
// in ST_P2_REQ and ST_P2_CHK, and waits while a result cannot be placed.
// Reset empties the graph at once through per-row valid bits; no clearing pass.
// A result waiting in the output register does not block a new input transfer;
// the search stalls only when a further result must be placed.
module strongly_connected_components
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] from_vertex, [13:7] to_vertex, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] vertex, [11:6] component, rest zero
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] end_of_component, [1] bad_vertex
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scc_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_ADD_WR,
        ST_BAD,
        ST_P1_ROOT,
        ST_P1_LOAD,
        ST_P1_SCAN,
        ST_P1_POPR,
        ST_P2_POP,
        ST_P2_FRD,
        ST_P2_REQ,
        ST_P2_CHK,
        ST_P2_WRD,
        ST_RUN_END
    } state_t;

    logic [MAX_V-1:0] adj_mem [MAX_V];
    logic [SW-1:0]    stk_mem [2*MAX_V];

    state_t           state_reg, state_next;
    logic [CW-1:0]    vc_reg;
    logic [MAX_V-1:0] adj_vld_reg, adj_vld_next;
    logic [MAX_V-1:0] adj_q;
    logic             adj_rd_vld_reg;
    logic [SW-1:0]    stk_q;
    logic [MAX_V-1:0] vis_reg, vis_next;
    logic [MAX_V-1:0] row_reg, row_next;
    logic [VW-1:0]    src_reg, src_next;
    logic [VW-1:0]    dst_reg, dst_next;
    logic [CW-1:0]    root_reg, root_next;
    logic [VW-1:0]    top_v_reg, top_v_next;
    logic [CW-1:0]    top_u_reg, top_u_next;
    logic [CW-1:0]    wdepth_reg, wdepth_next;
    logic [CW-1:0]    fdepth_reg, fdepth_next;
    logic [VW-1:0]    comp_reg, comp_next;
    logic             held_valid_reg, held_valid_next;
    logic [VW-1:0]    held_v_reg, held_v_next;
    logic [VW-1:0]    held_c_reg, held_c_next;
    logic             held_eoc_reg, held_eoc_next;
    logic             m_valid_reg;
    logic [VW-1:0]    m_vertex_reg, m_comp_reg;
    logic             m_eoc_reg, m_eor_reg, m_bad_reg;

    logic             adj_re, adj_we;
    logic [VW-1:0]    adj_ra, adj_wa;
    logic [MAX_V-1:0] adj_wd;
    logic             stk_re, stk_we;
    logic [CW-1:0]    stk_ra, stk_wa;
    logic [SW-1:0]    stk_wd;
    logic             out_load;
    logic [VW-1:0]    out_vertex, out_comp;
    logic             out_eoc, out_eor, out_bad;

    logic [CW-1:0]    n_act;
    logic [MAX_V-1:0] rowdata;
    logic             out_free;
    logic             can_emit;
    logic [VW-1:0]    u_idx;
    logic [CW-1:0]    wdm1, wdm2, fdm1;
    logic [CW-1:0]    s_from, s_to;
    op_t              s_op;

    assign pready = 1'b1;
    assign prdata = (paddr == {REG_VERTEX_COUNT, 2'b00}) ?
                    {{(32-CW){1'b0}}, vc_reg} : 32'd0;

    assign n_act = (vc_reg == '0) ? CW'(1) :
                   (vc_reg > CW'(MAX_V)) ? CW'(MAX_V) : vc_reg;
    assign rowdata  = adj_rd_vld_reg ? adj_q : '0;
    assign out_free = !m_valid_reg || m_tready;
    assign can_emit = !held_valid_reg || out_free;
    assign u_idx    = top_u_reg[VW-1:0];
    assign wdm1     = wdepth_reg - CW'(1);
    assign wdm2     = wdepth_reg - CW'(2);
    assign fdm1     = fdepth_reg - CW'(1);
    assign s_from   = s_tdata[CW-1:0];
    assign s_to     = s_tdata[2*CW-1:CW];
    assign s_op     = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-2*VW){1'b0}}, m_comp_reg, m_vertex_reg};
    assign m_tlast  = m_eor_reg;
    assign m_tuser  = {m_bad_reg, m_eoc_reg};

    always_comb
    begin
        state_next      = state_reg;
        adj_vld_next    = adj_vld_reg;
        vis_next        = vis_reg;
        row_next        = row_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        root_next       = root_reg;
        top_v_next      = top_v_reg;
        top_u_next      = top_u_reg;
        wdepth_next     = wdepth_reg;
        fdepth_next     = fdepth_reg;
        comp_next       = comp_reg;
        held_valid_next = held_valid_reg;
        held_v_next     = held_v_reg;
        held_c_next     = held_c_reg;
        held_eoc_next   = held_eoc_reg;
        adj_re = 1'b0;
        adj_ra = '0;
        adj_we = 1'b0;
        adj_wa = '0;
        adj_wd = '0;
        stk_re = 1'b0;
        stk_ra = '0;
        stk_we = 1'b0;
        stk_wa = '0;
        stk_wd = '0;
        out_load   = 1'b0;
        out_vertex = held_v_reg;
        out_comp   = held_c_reg;
        out_eoc    = held_eoc_reg;
        out_eor    = 1'b0;
        out_bad    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_op)
                        OP_ADD:
                        begin
                            if (s_from >= n_act || s_to >= n_act)
                            begin
                                state_next = ST_BAD;
                            end
                            else
                            begin
                                adj_re     = 1'b1;
                                adj_ra     = s_from[VW-1:0];
                                src_next   = s_from[VW-1:0];
                                dst_next   = s_to[VW-1:0];
                                state_next = ST_ADD_WR;
                            end
                        end
                        OP_CLR:
                        begin
                            adj_vld_next = '0;
                        end
                        OP_RUN:
                        begin
                            vis_next    = '0;
                            fdepth_next = '0;
                            root_next   = '0;
                            state_next  = ST_P1_ROOT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ADD_WR:
            begin
                adj_we = 1'b1;
                adj_wa = src_reg;
                adj_wd = rowdata | (MAX_V'(1) << dst_reg);
                adj_vld_next[src_reg] = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BAD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_vertex = '0;
                    out_comp   = '0;
                    out_eoc    = 1'b0;
                    out_eor    = 1'b1;
                    out_bad    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_P1_ROOT:
            begin
                if (root_reg == n_act)
                begin
                    vis_next   = '0;
                    comp_next  = '0;
                    state_next = ST_P2_POP;
                end
                else if (vis_reg[root_reg[VW-1:0]])
                begin
                    root_next = root_reg + CW'(1);
                end
                else
                begin
                    vis_next[root_reg[VW-1:0]] = 1'b1;
                    top_v_next  = root_reg[VW-1:0];
                    top_u_next  = '0;
                    wdepth_next = CW'(1);
                    adj_re      = 1'b1;
                    adj_ra      = root_reg[VW-1:0];
                    state_next  = ST_P1_LOAD;
                end
            end
            ST_P1_LOAD:
            begin
                row_next   = rowdata;
                state_next = ST_P1_SCAN;
            end
            ST_P1_SCAN:
            begin
                if (top_u_reg == n_act)
                begin
                    stk_we      = 1'b1;
                    stk_wa      = {1'b1, fdepth_reg[VW-1:0]};
                    stk_wd      = {{CW{1'b0}}, top_v_reg};
                    fdepth_next = fdepth_reg + CW'(1);
                    wdepth_next = wdm1;
                    if (wdepth_reg == CW'(1))
                    begin
                        state_next = ST_P1_ROOT;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        stk_ra     = {1'b0, wdm2[VW-1:0]};
                        state_next = ST_P1_POPR;
                    end
                end
                else if (row_reg[u_idx] && !vis_reg[u_idx])
                begin
                    stk_we           = 1'b1;
                    stk_wa           = {1'b0, wdm1[VW-1:0]};
                    stk_wd           = {top_u_reg + CW'(1), top_v_reg};
                    vis_next[u_idx]  = 1'b1;
                    top_v_next       = u_idx;
                    top_u_next       = '0;
                    wdepth_next      = wdepth_reg + CW'(1);
                    adj_re           = 1'b1;
                    adj_ra           = u_idx;
                    state_next       = ST_P1_LOAD;
                end
                else
                begin
                    top_u_next = top_u_reg + CW'(1);
                end
            end
            ST_P1_POPR:
            begin
                top_v_next = stk_q[VW-1:0];
                top_u_next = stk_q[SW-1:VW];
                adj_re     = 1'b1;
                adj_ra     = stk_q[VW-1:0];
                state_next = ST_P1_LOAD;
            end
            ST_P2_POP:
            begin
                if (fdepth_reg == '0)
                begin
                    state_next = ST_RUN_END;
                end
                else
                begin
                    fdepth_next = fdm1;
                    stk_re      = 1'b1;
                    stk_ra      = {1'b1, fdm1[VW-1:0]};
                    state_next  = ST_P2_FRD;
                end
            end
            ST_P2_FRD:
            begin
                if (vis_reg[stk_q[VW-1:0]])
                begin
                    state_next = ST_P2_POP;
                end
                else if (can_emit)
                begin
                    out_load        = held_valid_reg;
                    held_valid_next = 1'b1;
                    held_v_next     = stk_q[VW-1:0];
                    held_c_next     = comp_reg;
                    held_eoc_next   = 1'b0;
                    vis_next[stk_q[VW-1:0]] = 1'b1;
                    top_v_next      = stk_q[VW-1:0];
                    top_u_next      = '0;
                    wdepth_next     = CW'(1);
                    state_next      = ST_P2_REQ;
                end
            end
            ST_P2_REQ:
            begin
                if (top_u_reg == n_act)
                begin
                    wdepth_next = wdm1;
                    if (wdepth_reg == CW'(1))
                    begin
                        held_eoc_next = 1'b1;
                        comp_next     = comp_reg + VW'(1);
                        state_next    = ST_P2_POP;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        stk_ra     = {1'b0, wdm2[VW-1:0]};
                        state_next = ST_P2_WRD;
                    end
                end
                else
                begin
                    adj_re     = 1'b1;
                    adj_ra     = u_idx;
                    state_next = ST_P2_CHK;
                end
            end
            ST_P2_CHK:
            begin
                if (rowdata[top_v_reg] && !vis_reg[u_idx])
                begin
                    if (can_emit)
                    begin
                        out_load        = held_valid_reg;
                        held_valid_next = 1'b1;
                        held_v_next     = u_idx;
                        held_c_next     = comp_reg;
                        held_eoc_next   = 1'b0;
                        stk_we          = 1'b1;
                        stk_wa          = {1'b0, wdm1[VW-1:0]};
                        stk_wd          = {top_u_reg + CW'(1), top_v_reg};
                        vis_next[u_idx] = 1'b1;
                        top_v_next      = u_idx;
                        top_u_next      = '0;
                        wdepth_next     = wdepth_reg + CW'(1);
                        state_next      = ST_P2_REQ;
                    end
                end
                else
                begin
                    top_u_next = top_u_reg + CW'(1);
                    state_next = ST_P2_REQ;
                end
            end
            ST_P2_WRD:
            begin
                top_v_next = stk_q[VW-1:0];
                top_u_next = stk_q[SW-1:VW];
                state_next = ST_P2_REQ;
            end
            ST_RUN_END:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_eor         = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vc_reg         <= CW'(MAX_V);
            adj_vld_reg    <= '0;
            vis_reg        <= '0;
            root_reg       <= '0;
            wdepth_reg     <= '0;
            fdepth_reg     <= '0;
            comp_reg       <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            adj_vld_reg    <= adj_vld_next;
            vis_reg        <= vis_next;
            root_reg       <= root_next;
            wdepth_reg     <= wdepth_next;
            fdepth_reg     <= fdepth_next;
            comp_reg       <= comp_next;
            held_valid_reg <= held_valid_next;
            if (psel && penable && pwrite && pready && paddr == {REG_VERTEX_COUNT, 2'b00})
            begin
                vc_reg <= pwdata[CW-1:0];
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        top_v_reg    <= top_v_next;
        top_u_reg    <= top_u_next;
        held_v_reg   <= held_v_next;
        held_c_reg   <= held_c_next;
        held_eoc_reg <= held_eoc_next;
        if (out_load)
        begin
            m_vertex_reg <= out_vertex;
            m_comp_reg   <= out_comp;
            m_eoc_reg    <= out_eoc;
            m_eor_reg    <= out_eor;
            m_bad_reg    <= out_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_wa] <= adj_wd;
        end
        if (adj_re)
        begin
            adj_q          <= adj_mem[adj_ra];
            adj_rd_vld_reg <= adj_vld_reg[adj_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_q <= stk_mem[stk_ra];
        end
    end

    a_wdepth_max: assert property (@(posedge clk) disable iff (!rst_n)
        wdepth_reg <= CW'(MAX_V))
        else $error("walk stack depth exceeds the vertex limit");

    a_fdepth_max: assert property (@(posedge clk) disable iff (!rst_n)
        fdepth_reg <= CW'(MAX_V))
        else $error("finish stack depth exceeds the vertex limit");

    a_run_end_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN_END |-> held_valid_reg)
        else $error("run ends without a pending vertex result");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded while the output register is occupied");

    a_walk_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P1_ROOT || state_reg == ST_P2_POP) |-> wdepth_reg == '0 ||
        $past(state_reg) == ST_IDLE || $past(state_reg) == ST_P1_ROOT ||
        $past(state_reg) == ST_P1_SCAN || $past(state_reg) == ST_P2_REQ ||
        $past(state_reg) == ST_P2_FRD || $past(state_reg) == ST_P2_POP)
        else $error("search restarts with a nonempty walk stack");

endmodule

>>> tb/scc_checker.sv
`timescale 1ns / 100ps
// Checker for the strongly connected components block: watches the input,
// output and APB channels, predicts every result and compares field by field.
// Depends on scc_pkg for the operation codes and register index.
module scc_checker
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          results_checked
);

    typedef struct packed
    {
        logic [5:0] vertex;
        logic [5:0] component;
        logic       end_of_component;
        logic       end_of_run;
        logic       bad_vertex;
    } scc_result_t;

    logic [63:0]  edge_rows [MAX_V];
    logic [6:0]   vertex_count;
    scc_result_t  expected_results [$];

    function automatic int active_vertices();
        if (vertex_count == 0)
            return 1;
        if (vertex_count > MAX_V)
            return MAX_V;
        return int'(vertex_count);
    endfunction

    function automatic void queue_result(int v, int comp, bit bad);
        scc_result_t r;
        r.vertex = v[5:0];
        r.component = comp[5:0];
        r.end_of_component = 1'b0;
        r.end_of_run = bad;
        r.bad_vertex = bad;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void predict_components();
        int n;
        logic [63:0] seen;
        int fstk [MAX_V];
        int fdepth;
        int vstk [MAX_V];
        int rstk [MAX_V];
        int depth;
        int u;
        int v;
        int comp;
        n = active_vertices();
        seen = '0;
        depth = 0;
        fdepth = 0;
        for (int root = 0; root < n; root++)
        begin
            if (seen[root])
                continue;
            seen[root] = 1'b1;
            vstk[0] = root;
            rstk[0] = 0;
            depth = 1;
            while (depth > 0)
            begin
                v = vstk[depth-1];
                u = rstk[depth-1];
                while (u < n && !(edge_rows[v][u] && !seen[u]))
                    u++;
                if (u < n)
                begin
                    rstk[depth-1] = u + 1;
                    seen[u] = 1'b1;
                    vstk[depth] = u;
                    rstk[depth] = 0;
                    depth++;
                end
                else
                begin
                    depth--;
                    fstk[fdepth] = v;
                    fdepth++;
                end
            end
        end
        // The second pass follows incoming edges, i.e. matrix columns.
        seen = '0;
        comp = 0;
        while (fdepth > 0)
        begin
            fdepth--;
            v = fstk[fdepth];
            if (seen[v])
                continue;
            seen[v] = 1'b1;
            queue_result(v, comp, 1'b0);
            vstk[0] = v;
            rstk[0] = 0;
            depth = 1;
            while (depth > 0)
            begin
                v = vstk[depth-1];
                u = rstk[depth-1];
                while (u < n && !(edge_rows[u][v] && !seen[u]))
                    u++;
                if (u < n)
                begin
                    rstk[depth-1] = u + 1;
                    seen[u] = 1'b1;
                    queue_result(u, comp, 1'b0);
                    vstk[depth] = u;
                    rstk[depth] = 0;
                    depth++;
                end
                else
                    depth--;
            end
            expected_results[expected_results.size()-1].end_of_component = 1'b1;
            comp++;
        end
        expected_results[expected_results.size()-1].end_of_run = 1'b1;
    endfunction

    function automatic void predict_transfer(op_t op, int src, int dst);
        int n;
        n = active_vertices();
        case (op)
            OP_ADD:
                if (src >= n || dst >= n)
                    queue_result(0, 0, 1'b1);
                else
                    edge_rows[src][dst] = 1'b1;
            OP_CLR:
                foreach (edge_rows[i])
                    edge_rows[i] = '0;
            OP_RUN:
                predict_components();
            default: ;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scc_result_t got;
        scc_result_t want;
        if (!rst_n)
        begin
            foreach (edge_rows[i])
                edge_rows[i] = '0;
            vertex_count = 7'd64;
            expected_results.delete();
            fail_count = 0;
            results_checked = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == {REG_VERTEX_COUNT, 2'b00})
                vertex_count = pwdata[6:0];
            if (s_tvalid && s_tready)
                predict_transfer(op_t'(s_tuser), int'(s_tdata[6:0]), int'(s_tdata[13:7]));
            if (m_tvalid && m_tready)
            begin
                got.vertex = m_tdata[5:0];
                got.component = m_tdata[11:6];
                got.end_of_component = m_tuser[0];
                got.end_of_run = m_tlast;
                got.bad_vertex = m_tuser[1];
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result v=%0d c=%0d eoc=%0b eor=%0b bad=%0b",
                                 $realtime, got.vertex, got.component,
                                 got.end_of_component, got.end_of_run, got.bad_vertex);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch expected v=%0d c=%0d eoc=%0b eor=%0b ",
                                      "bad=%0b, got v=%0d c=%0d eoc=%0b eor=%0b bad=%0b"},
                                     $realtime, want.vertex, want.component,
                                     want.end_of_component, want.end_of_run,
                                     want.bad_vertex, got.vertex, got.component,
                                     got.end_of_component, got.end_of_run,
                                     got.bad_vertex);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> tb/strongly_connected_components_test.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the strongly connected components block: graph
// loads, clears and searches over several vertex counts, with random gaps.
// Depends on scc_pkg, strongly_connected_components and scc_checker.
module strongly_connected_components_test;
    import scc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [6:0] from_vertex, [13:7] to_vertex, rest zero
    logic [1:0]  s_tuser;   // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [5:0] vertex, [11:6] component, rest zero
    logic        m_tlast;
    logic [1:0]  m_tuser;   // [0] end_of_component, [1] bad_vertex
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int results_checked;
    int hold_cycles;
    bit steady_ready;
    int items_sent;
    int runs_sent;

    strongly_connected_components u_dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    scc_checker u_checker
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
        .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending), .results_checked(results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // The receiver stalls at random, except during a long hold or a steady stretch.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (steady_ready)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) < 70);
        end
    end

    task automatic send_item(op_t op, logic [6:0] src, logic [6:0] dst);
        int gap;
        gap = steady_ready ? 0 : random_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, dst, src};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op != OP_NOP)
            items_sent++;
        if (op == OP_RUN)
            runs_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [6:0] value);
        wait_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_VERTEX_COUNT, 2'b00};
        pwdata <= {25'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int count;
        int r;
        count = $urandom_range(16, 8);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 72)
                send_item(OP_ADD, 7'($urandom_range(n - 1)), 7'($urandom_range(n - 1)));
            else if (r < 82)
                send_item(OP_ADD, 7'($urandom_range(127)), 7'($urandom_range(127)));
            else if (r < 86)
                send_item(OP_CLR, 7'($urandom_range(127)), 7'($urandom_range(127)));
            else if (r < 89)
                send_item(OP_NOP, 7'($urandom_range(127)), 7'($urandom_range(127)));
            else
                send_item(OP_RUN, 7'($urandom_range(127)), 7'($urandom_range(127)));
        end
        send_item(OP_RUN, 7'd0, 7'd0);
    endtask

    initial
    begin
        int n;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_NOP;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        hold_cycles = 0;
        steady_ready = 1'b0;
        items_sent = 0;
        runs_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full size after reset: empty graph, a cycle, rejects and duplicates.
        send_item(OP_RUN, 7'd0, 7'd0);
        send_item(OP_ADD, 7'd0, 7'd63);
        send_item(OP_ADD, 7'd63, 7'd0);
        send_item(OP_ADD, 7'd127, 7'd0);
        send_item(OP_ADD, 7'd0, 7'd127);
        send_item(OP_ADD, 7'd64, 7'd64);
        send_item(OP_ADD, 7'd0, 7'd63);
        send_item(OP_NOP, 7'd127, 7'd127);
        hold_cycles = 400;
        send_item(OP_RUN, 7'd0, 7'd0);
        send_item(OP_ADD, 7'd1, 7'd2);
        send_item(OP_ADD, 7'd2, 7'd1);
        send_item(OP_ADD, 7'd2, 7'd3);
        send_item(OP_RUN, 7'd0, 7'd0);
        wait_idle();
        steady_ready = 1'b1;
        send_item(OP_CLR, 7'd0, 7'd0);
        send_item(OP_RUN, 7'd0, 7'd0);
        steady_ready = 1'b0;

        write_vertex_count(7'd1);
        send_item(OP_ADD, 7'd0, 7'd0);
        send_item(OP_ADD, 7'd1, 7'd0);
        send_item(OP_RUN, 7'd0, 7'd0);
        write_vertex_count(7'd0);
        send_item(OP_ADD, 7'd0, 7'd1);
        send_item(OP_RUN, 7'd0, 7'd0);
        write_vertex_count(7'd127);
        send_item(OP_RUN, 7'd0, 7'd0);

        while (items_sent < 100)
        begin
            case ($urandom_range(9))
                0: n = 64;
                1: n = 2;
                default: n = $urandom_range(16, 3);
            endcase
            write_vertex_count(7'(n));
            steady_ready = ($urandom_range(3) == 0);
            random_phase(n);
            steady_ready = 1'b0;
        end

        wait_idle();
        repeat (100) @(posedge clk);
        $display("Sent %0d items including %0d component searches over several vertex counts;",
                 items_sent, runs_sent);
        $display("checked %0d results, %0d of them failed.", results_checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
